FILE: design/osfc_pkg.sv
// Shared constants, codes and types for the ordered set floor/ceiling block.
package osfc_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_FLOOR   = 2'd1;
    localparam logic [1:0] OP_CEILING = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
        logic floor_sel;
    } cell_ctrl_t;

endpackage

FILE: design/osfc_cell.sv
// One slot of the sorted key chain: stores a key, compares it and shifts on insert.
module osfc_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  osfc_pkg::cell_ctrl_t              ctrl,
    input  logic signed [osfc_pkg::KEY_W-1:0] query,
    input  logic                              valid,
    input  logic signed [osfc_pkg::KEY_W-1:0] prev_key,
    input  logic                              prev_lt,
    input  logic                              next_lt,
    output logic signed [osfc_pkg::KEY_W-1:0] cell_key,
    output logic                              lt,
    output logic                              eq,
    output logic                              hit,
    output logic [osfc_pkg::KEY_W-1:0]        sel_key
);

    logic signed [osfc_pkg::KEY_W-1:0] key_reg;
    logic signed [osfc_pkg::KEY_W-1:0] key_next;
    logic                              lt_reg;
    logic                              lt_next;
    logic                              eq_reg;
    logic                              eq_next;
    logic                              floor_hit;
    logic                              ceil_hit;

    assign lt_next = valid && (key_reg < query);
    assign eq_next = valid && (key_reg == query);

    // The last key below the query is the floor candidate; the first stored
    // key not below it is the ceiling.
    assign floor_hit = lt_reg && !next_lt;
    assign ceil_hit  = valid && !lt_reg && prev_lt;
    assign hit       = ctrl.floor_sel ? floor_hit : ceil_hit;
    assign sel_key   = hit ? key_reg : '0;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.shift_en && !lt_reg)
        begin
            key_next = prev_lt ? query : prev_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    assign cell_key = key_reg;
    assign lt       = lt_reg;
    assign eq       = eq_reg;

endmodule

FILE: design/ordered_set_floor_ceiling.sv
// Top level of the ordered set: request control, cell chain and result register.
//
//   channel | handshake            | payload          | direction
//   req     | req_valid, req_stall | op, key          | in (stall out)
//   rsp     | rsp_valid, rsp_stall | status, result_key | out (stall in)
//
// A request is latched at the edge that accepts it. In the compare state every
// cell registers how its key compares with the query; in the answer state the
// answer is picked into the result register and the chain shifts on insert, and
// a new request is taken only after the previous one has left the answer state.
// After reset the set is empty and no request is pending.
// A stalled result holds in its register; the next request may still be
// accepted and waits before its answer stage until the result is taken.
module ordered_set_floor_ceiling (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [1:0]                        op,
    input  logic signed [osfc_pkg::KEY_W-1:0] key,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [1:0]                        status,
    output logic signed [osfc_pkg::KEY_W-1:0] result_key
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RES
    } state_t;

    state_t                            state_reg;
    logic [1:0]                        op_reg;
    logic signed [osfc_pkg::KEY_W-1:0] query_reg;
    logic [osfc_pkg::CNT_W-1:0]        count_reg;
    logic                              rsp_valid_reg;
    logic [1:0]                        status_reg;
    logic signed [osfc_pkg::KEY_W-1:0] result_reg;

    osfc_pkg::cell_ctrl_t              ctrl;
    logic signed [osfc_pkg::KEY_W-1:0] cell_key [osfc_pkg::CAPACITY];
    logic [osfc_pkg::KEY_W-1:0]        sel_key  [osfc_pkg::CAPACITY];
    logic [osfc_pkg::CAPACITY-1:0]     cell_lt;
    logic [osfc_pkg::CAPACITY-1:0]     cell_eq;
    logic [osfc_pkg::CAPACITY-1:0]     cell_hit;
    logic [osfc_pkg::KEY_W-1:0]        sel_or;
    logic                              any_eq;
    logic                              any_hit;
    logic                              full;
    logic                              out_free;
    logic                              do_insert;
    logic [1:0]                        status_next;
    logic signed [osfc_pkg::KEY_W-1:0] result_next;

    assign full      = (count_reg == osfc_pkg::CNT_W'(osfc_pkg::CAPACITY));
    assign any_eq    = |cell_eq;
    assign any_hit   = |cell_hit;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign do_insert = (state_reg == S_RES) && out_free && (op_reg == osfc_pkg::OP_INSERT)
                       && !any_eq && !full;

    assign ctrl.cmp_en    = (state_reg == S_CMP);
    assign ctrl.shift_en  = do_insert;
    assign ctrl.floor_sel = (op_reg == osfc_pkg::OP_FLOOR);

    for (genvar i = 0; i < osfc_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [osfc_pkg::KEY_W-1:0] prev_key;
        logic                              prev_lt;
        logic                              next_lt;
        logic                              valid;

        assign valid = (count_reg > osfc_pkg::CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign prev_key = query_reg;
            assign prev_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign prev_key = cell_key[i-1];
            assign prev_lt  = cell_lt[i-1];
        end

        if (i == osfc_pkg::CAPACITY - 1)
        begin : g_last
            assign next_lt = 1'b0;
        end
        else
        begin : g_inner
            assign next_lt = cell_lt[i+1];
        end

        osfc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .query    (query_reg),
            .valid    (valid),
            .prev_key (prev_key),
            .prev_lt  (prev_lt),
            .next_lt  (next_lt),
            .cell_key (cell_key[i]),
            .lt       (cell_lt[i]),
            .eq       (cell_eq[i]),
            .hit      (cell_hit[i]),
            .sel_key  (sel_key[i])
        );
    end

    // At most one cell hits, so an OR over the masked keys selects it.
    always_comb
    begin
        sel_or = '0;
        for (int i = 0; i < osfc_pkg::CAPACITY; i++)
        begin
            sel_or = sel_or | sel_key[i];
        end
    end

    always_comb
    begin
        status_next = osfc_pkg::ST_NOT_FOUND;
        result_next = '0;
        case (op_reg)
            osfc_pkg::OP_INSERT:
            begin
                result_next = query_reg;
                if (any_eq)
                begin
                    status_next = osfc_pkg::ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = osfc_pkg::ST_FULL;
                end
                else
                begin
                    status_next = osfc_pkg::ST_OK;
                end
            end
            osfc_pkg::OP_FLOOR:
            begin
                if (any_eq)
                begin
                    status_next = osfc_pkg::ST_OK;
                    result_next = query_reg;
                end
                else if (any_hit)
                begin
                    status_next = osfc_pkg::ST_OK;
                    result_next = sel_or;
                end
            end
            osfc_pkg::OP_CEILING:
            begin
                if (any_hit)
                begin
                    status_next = osfc_pkg::ST_OK;
                    result_next = sel_or;
                end
            end
            default:
            begin
                status_next = osfc_pkg::ST_NOT_FOUND;
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // In the answer state a taken result is replaced by the new one below.
            if (rsp_valid_reg && !rsp_stall && state_reg != S_RES)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (do_insert)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            op_reg    <= op;
            query_reg <= key;
        end
        if (state_reg == S_RES && out_free)
        begin
            status_reg <= status_next;
            result_reg <= result_next;
        end
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign result_key = result_reg;

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RES |-> $onehot0(cell_hit))
        else $error("more than one cell claims the answer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= osfc_pkg::CNT_W'(osfc_pkg::CAPACITY))
        else $error("key count beyond capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("key count moved by other than one");

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_CMP)
        else $error("accepted request did not start a compare");

    a_shift_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift_en |-> !any_eq && !full && out_free)
        else $error("chain shifted for a duplicate or full table");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the ordered set floor/ceiling block.
module tb_top;
    import osfc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W - 1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W - 1){1'b1}}};
    localparam int RANDOM_REQS    = 1500;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 80;
    localparam int TIMEOUT_CYCLES = 200_000;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
    } set_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] result_key;
    } set_rsp_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    req_valid  = 1'b0;
    logic                    req_stall;
    logic [1:0]              op         = OP_INSERT;
    logic signed [KEY_W-1:0] key        = '0;
    logic                    rsp_valid;
    logic                    rsp_stall  = 1'b0;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] result_key;

    set_req_t                req_backlog[$];
    set_rsp_t                answers_due[$];
    logic signed [KEY_W-1:0] model_keys[$];
    logic signed [KEY_W-1:0] inserted_pool[$];

    int total_reqs     = 0;
    int accepted_cnt   = 0;
    int checked_cnt    = 0;
    int error_cnt      = 0;
    int hold_left      = 0;
    int backed_up_cnt  = 0;
    logic hold_done    = 1'b0;
    int op_seen[4]     = '{default: 0};
    int status_seen[4] = '{default: 0};
    int send_idle_pct;
    int recv_idle_pct;

    ordered_set_floor_ceiling u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .op         (op),
        .key        (key),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .result_key (result_key)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // The run moves through three idling phases as requests are accepted.
    assign send_idle_pct = (accepted_cnt < total_reqs / 3)     ? 19 :
                           (accepted_cnt < 2 * total_reqs / 3) ? 47 : 0;
    assign recv_idle_pct = (accepted_cnt < total_reqs / 3)     ? 47 :
                           (accepted_cnt < 2 * total_reqs / 3) ? 19 : 0;

    // Applies one request to the behavioral sorted set and returns its answer.
    function automatic set_rsp_t answer_request(input set_req_t req);
        set_rsp_t                rsp;
        logic signed [KEY_W-1:0] k;
        int                      pos;
        bit                      exact;
        k   = req.key;
        pos = 0;
        while (pos < model_keys.size() && model_keys[pos] < k)
            pos++;
        exact          = (pos < model_keys.size()) && (model_keys[pos] == k);
        rsp.status     = ST_NOT_FOUND;
        rsp.result_key = '0;
        case (req.op)
            OP_INSERT:
            begin
                rsp.result_key = k;
                if (exact)
                    rsp.status = ST_DUPLICATE;
                else if (model_keys.size() >= CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    model_keys.insert(pos, k);
                    rsp.status = ST_OK;
                end
            end
            OP_FLOOR:
            begin
                if (exact)
                begin
                    rsp.status     = ST_OK;
                    rsp.result_key = k;
                end
                else if (pos > 0)
                begin
                    rsp.status     = ST_OK;
                    rsp.result_key = model_keys[pos - 1];
                end
            end
            OP_CEILING:
            begin
                if (pos < model_keys.size())
                begin
                    rsp.status     = ST_OK;
                    rsp.result_key = model_keys[pos];
                end
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    task automatic queue_req(input logic [1:0] req_op, input logic signed [KEY_W-1:0] req_key);
        req_backlog.push_back({req_op, req_key});
        if (req_op == OP_INSERT)
            inserted_pool.push_back(req_key);
    endtask

    initial
    begin
        int unsigned             pick;
        int unsigned             idx;
        int                      ins_pct;
        logic [1:0]              rop;
        logic signed [KEY_W-1:0] rkey;

        // Empty set, then a single key with nothing on either side of it.
        queue_req(OP_FLOOR, '0);
        queue_req(OP_CEILING, '0);
        queue_req(OP_UNUSED, '0);
        queue_req(OP_INSERT, '0);
        queue_req(OP_FLOOR, -5);
        queue_req(OP_CEILING, 5);
        queue_req(OP_INSERT, KEY_MIN);
        queue_req(OP_INSERT, KEY_MAX);
        queue_req(OP_INSERT, -1);
        queue_req(OP_INSERT, '0);
        queue_req(OP_FLOOR, KEY_MIN);
        queue_req(OP_CEILING, KEY_MAX);
        queue_req(OP_FLOOR, -2);
        queue_req(OP_CEILING, -2);
        queue_req(OP_CEILING, 1);
        queue_req(OP_FLOOR, 1);
        queue_req(OP_FLOOR, KEY_MAX);
        queue_req(OP_CEILING, KEY_MIN);
        queue_req(OP_INSERT, 100);
        queue_req(OP_FLOOR, 50);
        queue_req(OP_CEILING, 50);
        queue_req(OP_UNUSED, 100);
        queue_req(OP_CEILING, KEY_MAX - 1);
        queue_req(OP_INSERT, 32'h5555_5555);
        queue_req(OP_INSERT, 32'hAAAA_AAAA);

        // Inserts are rare at first so queries see the set at many fill levels;
        // later the set is full and inserts split between drops and duplicates.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick    = $urandom_range(99);
            ins_pct = (n < 800) ? 12 : 35;
            if (pick < ins_pct)
                rop = OP_INSERT;
            else if (pick < 55)
                rop = OP_FLOOR;
            else if (pick < 95)
                rop = OP_CEILING;
            else
                rop = OP_UNUSED;
            idx = $urandom_range(inserted_pool.size() - 1);
            case ($urandom_range(9))
                0, 1, 2, 3, 9:
                    rkey = $urandom();
                4, 5:
                    rkey = inserted_pool[idx];
                6:
                begin
                    rkey = inserted_pool[idx];
                    rkey = $urandom_range(1) ? rkey + 1 : rkey - 1;
                end
                7:
                    rkey = $urandom_range(16) - 8;
                default:
                begin
                    case ($urandom_range(3))
                        0:       rkey = KEY_MIN;
                        1:       rkey = KEY_MAX;
                        2:       rkey = KEY_MIN + 1;
                        default: rkey = KEY_MAX - 1;
                    endcase
                end
            endcase
            queue_req(rop, rkey);
        end
        total_reqs = req_backlog.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || req_valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d insert, %0d floor, %0d ceiling, %0d unused op; %0d keys held.",
                 accepted_cnt, op_seen[OP_INSERT], op_seen[OP_FLOOR], op_seen[OP_CEILING],
                 op_seen[OP_UNUSED], model_keys.size());
        $display("Checked %0d results: ok %0d, not found %0d, full %0d, duplicate %0d; %0d stalls.",
                 checked_cnt, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_DUPLICATE], backed_up_cnt);
        if (error_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Request driver: a new request is offered only once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            op        <= OP_INSERT;
            key       <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
            begin
                answers_due.push_back(answer_request({op, key}));
                op_seen[op]++;
                accepted_cnt <= accepted_cnt + 1;
            end
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                op        <= req_backlog[0].op;
                key       <= req_backlog[0].key;
                void'(req_backlog.pop_front());
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Long output hold-off late in the run, while the driver offers every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (hold_left != 0 && req_valid && req_stall)
                backed_up_cnt <= backed_up_cnt + 1;
            if (!hold_done && accepted_cnt >= total_reqs * 5 / 6)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // Result monitor and output stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid === 1'b1 && !rsp_stall)
            begin : check_rsp
                set_rsp_t due;
                if (answers_due.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d result_key %0d",
                             $time, status, result_key);
                    error_cnt++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    status_seen[due.status]++;
                    checked_cnt++;
                    if (status !== due.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, due.status, status);
                        error_cnt++;
                    end
                    if (result_key !== due.result_key)
                    begin
                        $display("%0t: result_key mismatch: expected %0d actual %0d",
                                 $time, due.result_key, result_key);
                        error_cnt++;
                    end
                end
            end
            rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 20);
        $display("Timeout with %0d results outstanding", answers_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/osfc_pkg.sv
design/osfc_cell.sv
design/ordered_set_floor_ceiling.sv
sim/tb_top.sv
